// ===== hdl/tccw_pkg.sv =====
package tccw_pkg;

    // Field widths fixed by the item formats.
    localparam int CELL_W = 11;
    localparam int CHAR_W = 8;

    // Character codes with a meaning of their own.
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One input request.
    typedef struct packed {
        logic              operation;
        logic [CHAR_W-1:0] char_code;
        logic [CELL_W-1:0] cell_index;
    } t_in_item;

    // One result request.
    typedef struct packed {
        logic [CELL_W-1:0] cursor_cell;
        logic [CHAR_W-1:0] read_char;
        logic              scrolled;
    } t_out_item;

    // Operation codes of an input request.
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Command kinds decided by the front.
    typedef enum logic [1:0] {
        K_PUT,
        K_NEWLINE,
        K_READ
    } t_kind;

    // A classified command as it sits in the queue.
    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] char_code;
        logic [CELL_W-1:0] cell_index;
    } t_cmd;

    // Head of the queue as seen by the back.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

// ===== hdl/text_console_char_writer.sv =====
// Channel   Handshake           Payload    Direction
// input     push / full         i_item     in: operation, char_code, cell_index
// result    empty / pop         o_result   out: cursor_cell, read_char, scrolled
//
// A put or newline is executed in the sequencer's run state; a read of an in-range cell
// goes on to a read state, fed by the registered read port of the character store.
// A scroll rotates the row base and then wipes one row of COLUMNS cells, stalling
// execution meanwhile; requests keep queuing in the 4-deep command queue.
// After reset all COLUMNS*ROWS cells of the store (2000 by default) are cleared to spaces;
// push is taken until the queue fills. A result left unpopped holds execution back.
module text_console_char_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  tccw_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output tccw_pkg::t_out_item o_result
);
    import tccw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    t_q_head           head;
    logic              take;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    // Front: classify requests and queue them.
    tccw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .o_head  (head),
        .i_take  (take)
    );

    // Back: execute commands against the store and the cursor.
    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_take      (take),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

    // Character store.
    tccw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// ===== hdl/tccw_ram.sv =====
module tccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tccw_front.sv =====
module tccw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  tccw_pkg::t_in_item i_item,
    output tccw_pkg::t_q_head  o_head,
    input  logic               i_take
);
    import tccw_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    t_cmd              cmd;
    logic              accept;
    logic              take;

    // Classify the incoming request into a command kind.
    always_comb begin
        cmd.char_code  = i_item.char_code;
        cmd.cell_index = i_item.cell_index;
        if (i_item.operation == OP_READ) begin
            cmd.kind = K_READ;
        end else if (i_item.char_code == NEWLINE_CODE) begin
            cmd.kind = K_NEWLINE;
        end else begin
            cmd.kind = K_PUT;
        end
    end

    assign o_full = (r_count == CNT_W'(QUEUE_DEPTH));
    assign accept = i_push && !o_full;
    assign take   = i_take && (r_count != '0);

    // Queue storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_queue[r_wr_ptr] <= cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (accept && !take) begin
                r_count <= r_count + 1'b1;
            end else if (take && !accept) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_queue[r_rd_ptr];

    // The fill count never passes the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // A request taken while none is drained raises the count by one.
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !take) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not rise on push");

    // The back only takes a command when the queue holds one.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> o_head.valid)
        else $error("take from empty queue");

endmodule

// ===== hdl/tccw_back.sv =====
module tccw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  tccw_pkg::t_q_head                         i_head,
    output logic                                      o_take,
    output logic                                      o_ram_we,
    output logic [$clog2(COLUMNS*ROWS)-1:0]           o_ram_waddr,
    output logic [tccw_pkg::CHAR_W-1:0]               o_ram_wdata,
    output logic                                      o_ram_re,
    output logic [$clog2(COLUMNS*ROWS)-1:0]           o_ram_raddr,
    input  logic [tccw_pkg::CHAR_W-1:0]               i_ram_rdata,
    output logic                                      o_empty,
    input  logic                                      i_pop,
    output tccw_pkg::t_out_item                       o_result
);
    import tccw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int SUM_W  = ((ADDR_W > CELL_W) ? ADDR_W : CELL_W) + 1;
    localparam logic [SUM_W-1:0] CELLS_S = SUM_W'(CELLS);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_RUN,
        S_READ
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_sweep, n_sweep;
    logic [ADDR_W-1:0] r_sweep_last, n_sweep_last;
    logic [ADDR_W-1:0] r_base_off, n_base_off;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ADDR_W-1:0] r_cursor, n_cursor;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              out_room;
    logic              take;
    logic [SUM_W-1:0]  rd_sum, rd_wrap;
    logic [SUM_W-1:0]  wr_sum, wr_wrap;
    logic              rd_in_range;
    logic [ROW_W-1:0]  adv_row;
    logic [COL_W-1:0]  adv_col;
    logic [ADDR_W-1:0] adv_cursor;
    logic              scroll;

    assign out_room = !r_out_valid || i_pop;
    assign take     = (r_state == S_RUN) && i_head.valid && out_room;
    assign o_take   = take;

    // Logical cell to physical address: rows rotate by the base offset.
    always_comb begin
        rd_sum      = SUM_W'(i_head.cmd.cell_index) + SUM_W'(r_base_off);
        rd_wrap     = (rd_sum >= CELLS_S) ? (rd_sum - CELLS_S) : rd_sum;
        rd_in_range = SUM_W'(i_head.cmd.cell_index) < CELLS_S;
        wr_sum      = SUM_W'(r_cursor) + SUM_W'(r_base_off);
        wr_wrap     = (wr_sum >= CELLS_S) ? (wr_sum - CELLS_S) : wr_sum;
    end

    // Cursor after a put or newline, before any scroll.
    always_comb begin
        if (i_head.cmd.kind == K_NEWLINE) begin
            adv_row    = r_row + 1'b1;
            adv_col    = '0;
            adv_cursor = r_cursor + ADDR_W'(COLUMNS) - ADDR_W'(r_col);
        end else if (r_col == COL_W'(COLUMNS - 1)) begin
            adv_row    = r_row + 1'b1;
            adv_col    = '0;
            adv_cursor = r_cursor + 1'b1;
        end else begin
            adv_row    = r_row;
            adv_col    = r_col + 1'b1;
            adv_cursor = r_cursor + 1'b1;
        end
        scroll = (adv_row == ROW_W'(ROWS - 1));
    end

    // Sequencer: clearing sweeps, command execution and read completion.
    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_sweep_last = r_sweep_last;
        n_base_off   = r_base_off;
        n_row        = r_row;
        n_col        = r_col;
        n_cursor     = r_cursor;
        n_out_valid  = r_out_valid && !i_pop;
        n_out        = r_out;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_sweep;
        o_ram_wdata  = SPACE_CODE;
        o_ram_re     = 1'b0;
        o_ram_raddr  = ADDR_W'(rd_wrap);

        case (r_state)
            S_SWEEP: begin
                o_ram_we = 1'b1;
                if (r_sweep == r_sweep_last) begin
                    n_state = S_RUN;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_RUN: begin
                if (take) begin
                    if (i_head.cmd.kind == K_READ) begin
                        if (rd_in_range) begin
                            o_ram_re = 1'b1;
                            n_state  = S_READ;
                        end else begin
                            n_out_valid       = 1'b1;
                            n_out.cursor_cell = CELL_W'(r_cursor);
                            n_out.read_char   = '0;
                            n_out.scrolled    = 1'b0;
                        end
                    end else begin
                        if (i_head.cmd.kind == K_PUT) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = ADDR_W'(wr_wrap);
                            o_ram_wdata = i_head.cmd.char_code;
                        end
                        n_col = adv_col;
                        if (scroll) begin
                            // Rotate the rows and wipe the row that left the top.
                            n_row        = ROW_W'(ROWS - 2);
                            n_cursor     = adv_cursor - ADDR_W'(COLUMNS);
                            n_base_off   = (r_base_off == ADDR_W'(CELLS - COLUMNS)) ?
                                           '0 : (r_base_off + ADDR_W'(COLUMNS));
                            n_sweep      = r_base_off;
                            n_sweep_last = r_base_off + ADDR_W'(COLUMNS - 1);
                            n_state      = S_SWEEP;
                        end else begin
                            n_row    = adv_row;
                            n_cursor = adv_cursor;
                        end
                        n_out_valid       = 1'b1;
                        n_out.cursor_cell = CELL_W'(scroll ?
                                            (adv_cursor - ADDR_W'(COLUMNS)) : adv_cursor);
                        n_out.read_char   = '0;
                        n_out.scrolled    = scroll;
                    end
                end
            end
            S_READ: begin
                if (out_room) begin
                    n_out_valid       = 1'b1;
                    n_out.cursor_cell = CELL_W'(r_cursor);
                    n_out.read_char   = i_ram_rdata;
                    n_out.scrolled    = 1'b0;
                    n_state           = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_sweep      <= '0;
            r_sweep_last <= ADDR_W'(CELLS - 1);
            r_base_off   <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_cursor     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep      <= n_sweep;
            r_sweep_last <= n_sweep_last;
            r_base_off   <= n_base_off;
            r_row        <= n_row;
            r_col        <= n_col;
            r_cursor     <= n_cursor;
            r_out_valid  <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    // The cursor never rests on the last row.
    a_row_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row < ROW_W'(ROWS - 1))
        else $error("cursor on last row");

    // The linear cursor agrees with its row and column.
    a_cursor_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor == ADDR_W'(int'(r_row) * COLUMNS + int'(r_col)))
        else $error("cursor out of step with row and column");

    // A scrolling put or newline is reported and followed by a row wipe.
    a_scroll_wipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (i_head.cmd.kind != K_READ) && scroll)
        |=> (r_state == S_SWEEP) && r_out_valid && r_out.scrolled)
        else $error("scroll without wipe");

    // A finished read delivers a result that reports no scroll.
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_READ) && out_room) |=> r_out_valid && !r_out.scrolled)
        else $error("read completion lost");

    // Nothing is read from the store and no command is taken while a sweep writes it.
    a_sweep_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !o_ram_re && !take)
        else $error("store access during sweep");

endmodule

// ===== tb/tb_text_console_char_writer.sv =====
`timescale 1ns / 100ps

module tb_text_console_char_writer;

    import tccw_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int SCROLL_LIMIT = COLUMNS * (ROWS - 1);
    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 300;
    localparam int DRAIN_CYCLES = 200;

    // One row of the directed stimulus table.
    typedef struct {
        t_in_item  req;
        int        reps;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_result;

    // Shadow copy of the screen and cursor, plus the reports still owed by the block.
    logic [CHAR_W-1:0] screen_mem [0:CELLS-1];
    int                cursor;
    t_out_item         pending_reports [$];
    t_stim_row         stim_table [$];

    int  gap_pct = 0;
    int  stall_pct = 0;
    bit  hold_go = 1'b0;
    logic hold_on = 1'b0;
    int  mismatch_count = 0;
    int  error_count = 0;

    text_console_char_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // Clock and a single reset pulse at the start of the run.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Apply one request to the shadow console and return the report it should produce.
    function automatic t_out_item console_step(t_in_item req);
        t_out_item res;
        res = '0;
        if (req.operation == OP_READ) begin
            if (req.cell_index < CELLS) begin
                res.read_char = screen_mem[req.cell_index];
            end
        end else begin
            if (cursor >= CELLS) begin
                cursor = 0;
            end
            if (req.char_code == NEWLINE_CODE) begin
                cursor = (cursor / COLUMNS + 1) * COLUMNS;
            end else begin
                screen_mem[cursor] = req.char_code;
                cursor++;
            end
            // Shift rows up by one; the last row keeps what it held.
            if (cursor >= SCROLL_LIMIT) begin
                for (int i = 0; i < SCROLL_LIMIT; i++) begin
                    screen_mem[i] = screen_mem[i + COLUMNS];
                end
                cursor -= COLUMNS;
                res.scrolled = 1'b1;
            end
        end
        res.cursor_cell = cursor[CELL_W-1:0];
        return res;
    endfunction

    function automatic t_in_item make_req(logic op, logic [CHAR_W-1:0] ch,
                                          logic [CELL_W-1:0] idx);
        t_in_item req;
        req.operation  = op;
        req.char_code  = ch;
        req.cell_index = idx;
        return req;
    endfunction

    function automatic void add_row(logic op, logic [CHAR_W-1:0] ch, logic [CELL_W-1:0] idx,
                                    int reps, bit typed, logic [CELL_W-1:0] cur,
                                    logic [CHAR_W-1:0] rd, logic scr);
        t_stim_row row;
        row.req              = make_req(op, ch, idx);
        row.reps             = reps;
        row.typed            = typed;
        row.want.cursor_cell = cur;
        row.want.read_char   = rd;
        row.want.scrolled    = scr;
        stim_table.push_back(row);
    endfunction

    // Offer one request after idling each cycle with the sender's idle odds, and record
    // its expected report at the edge where it is taken.
    task automatic offer_request(t_in_item req, bit typed, t_out_item want);
        t_out_item predicted;
        while ($urandom_range(0, 99) < gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (full);
        predicted = console_step(req);
        pending_reports.push_back(typed ? want : predicted);
    endtask

    task automatic offer_plain(t_in_item req);
        offer_request(req, 1'b0, '0);
    endtask

    // Random traffic: mostly text lines with wrap-around, read bursts, and some raw noise.
    task automatic run_random_phase(int count);
        int                n;
        int                r;
        int                len;
        logic [CELL_W-1:0] idx;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                len = $urandom_range(0, 120);
                for (int k = 0; k < len; k++) begin
                    offer_plain(make_req(OP_PUT, CHAR_W'($urandom_range(0, 255)),
                                         CELL_W'($urandom_range(0, 2047))));
                end
                n += len;
                if ($urandom_range(0, 9) < 8) begin
                    offer_plain(make_req(OP_PUT, NEWLINE_CODE,
                                         CELL_W'($urandom_range(0, 2047))));
                    n++;
                end
            end else if (r < 90) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        idx = CELL_W'($urandom_range(0, 2047));
                    end else begin
                        idx = CELL_W'($urandom_range(0, CELLS - 1));
                    end
                    offer_plain(make_req(OP_READ, CHAR_W'($urandom_range(0, 255)), idx));
                end
                n += len;
            end else begin
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++) begin
                    offer_plain(make_req(1'($urandom_range(0, 1)),
                                         CHAR_W'($urandom_range(0, 255)),
                                         CELL_W'($urandom_range(0, 2047))));
                end
                n += len;
            end
        end
    endtask

    // Compare one report with the oldest expectation.
    task automatic check_report(t_out_item got);
        t_out_item want;
        if (pending_reports.size() == 0) begin
            error_count++;
            if (error_count + mismatch_count <= 10) begin
                $display("unexpected report: cursor %0d char %h scrolled %b",
                         got.cursor_cell, got.read_char, got.scrolled);
            end
        end else begin
            want = pending_reports.pop_front();
            if (got.cursor_cell !== want.cursor_cell || got.read_char !== want.read_char ||
                got.scrolled !== want.scrolled) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("report mismatch: cursor exp %0d got %0d, char exp %h got %h, %s",
                             want.cursor_cell, got.cursor_cell, want.read_char, got.read_char,
                             $sformatf("scrolled exp %b got %b", want.scrolled, got.scrolled));
                end
            end
        end
    endtask

    // Result side: check on every taken report, then pick the next pop at random.
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                check_report(o_result);
            end
            pop <= !hold_on && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Long hold-off of the result side so the queue fills and stalls the input.
    initial begin
        wait (hold_go);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Watchdog on cycles in which neither side moves a request.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    // Main sequence: directed table, then four random phases, then drain.
    initial begin
        for (int i = 0; i < CELLS; i++) begin
            screen_mem[i] = SPACE_CODE;
        end
        cursor = 0;

        // Fresh screen reads, range edges, zero and all-ones bytes, newline,
        // ignored fields, and a scroll driven by newlines.
        add_row(OP_READ, 8'hFF, 11'd0, 1, 1'b1, 11'd0, SPACE_CODE, 1'b0);
        add_row(OP_READ, 8'h00, 11'd1999, 1, 1'b1, 11'd0, SPACE_CODE, 1'b0);
        add_row(OP_READ, 8'h00, 11'd2000, 1, 1'b1, 11'd0, 8'h00, 1'b0);
        add_row(OP_READ, 8'h0A, 11'd2047, 1, 1'b1, 11'd0, 8'h00, 1'b0);
        add_row(OP_PUT, 8'h00, 11'd2047, 1, 1'b1, 11'd1, 8'h00, 1'b0);
        add_row(OP_PUT, 8'hFF, 11'd0, 1, 1'b1, 11'd2, 8'h00, 1'b0);
        add_row(OP_READ, 8'h00, 11'd0, 1, 1'b1, 11'd2, 8'h00, 1'b0);
        add_row(OP_READ, 8'h00, 11'd1, 1, 1'b1, 11'd2, 8'hFF, 1'b0);
        add_row(OP_PUT, NEWLINE_CODE, 11'd5, 1, 1'b1, 11'd80, 8'h00, 1'b0);
        add_row(OP_PUT, 8'h41, 11'h555, 1, 1'b0, '0, '0, 1'b0);
        add_row(OP_PUT, 8'h55, 11'h2AA, 1, 1'b0, '0, '0, 1'b0);
        add_row(OP_PUT, 8'hAA, 11'h555, 1, 1'b0, '0, '0, 1'b0);
        add_row(OP_PUT, NEWLINE_CODE, 11'd0, 23, 1'b0, '0, '0, 1'b0);
        add_row(OP_READ, 8'h00, 11'd0, 1, 1'b0, '0, '0, 1'b0);
        add_row(OP_READ, 8'h00, 11'd1840, 1, 1'b0, '0, '0, 1'b0);
        add_row(OP_READ, 8'h00, 11'd1999, 1, 1'b0, '0, '0, 1'b0);

        wait (i_rst_n);
        @(posedge i_clk);
        foreach (stim_table[r]) begin
            for (int k = 0; k < stim_table[r].reps; k++) begin
                offer_request(stim_table[r].req, stim_table[r].typed, stim_table[r].want);
            end
        end

        // No idling, with the long hold-off at its start.
        gap_pct   = 0;
        stall_pct = 0;
        hold_go   = 1'b1;
        run_random_phase(PHASE_ITEMS);
        gap_pct   = 78;
        stall_pct = 0;
        run_random_phase(PHASE_ITEMS);
        gap_pct   = 0;
        stall_pct = 78;
        run_random_phase(PHASE_ITEMS);
        gap_pct   = 25;
        stall_pct = 25;
        run_random_phase(PHASE_ITEMS);
        push <= 1'b0;

        while (pending_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && error_count == 0 && pending_reports.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tccw_pkg.sv
hdl/tccw_ram.sv
hdl/tccw_front.sv
hdl/tccw_back.sv
hdl/text_console_char_writer.sv
tb/tb_text_console_char_writer.sv
